FILE: src/c3en_pkg.sv
// shared types, constants and kernel helpers of the 3x3 edge-normalized filter
package c3en_pkg;

	localparam int VALUE_BITS = 19;
	localparam int WEIGHT_BITS = 9;
	localparam int SUM_BITS = 13;
	localparam int CFG_BITS = 64;
	localparam int CFG_IDX_BITS = 2;

	localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;

	localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_KERNEL_CENTER = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_KERNEL_RING = 2'd3;

	typedef logic signed [WEIGHT_BITS-1:0] weight_t;

	// position 4 is the center, the ring bytes fill the other positions in raster order
	function automatic weight_t weight_at(input logic [8:0] center, input logic [63:0] ring,
			input logic [3:0] pos);
		logic [2:0] byte_sel;
		logic [7:0] raw;
		byte_sel = (pos < 4'd4) ? pos[2:0] : 3'(pos - 4'd1);
		raw = ring[{byte_sel, 3'b000} +: 8];
		if (pos == 4'd4) begin
			weight_at = weight_t'(center);
		end else begin
			weight_at = weight_t'({raw[7], raw});
		end
	endfunction

	// lowest pending result slot
	function automatic logic [1:0] first_set(input logic [3:0] mask);
		logic [1:0] k;
		k = 2'd0;
		for (int i = 3; i >= 0; i--) begin
			if (mask[i]) k = 2'(i);
		end
		first_set = k;
	endfunction

endpackage

FILE: src/c3en_ram.sv
// generic single-port-write, single-port-read ram with registered read data
module c3en_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

FILE: src/conv3x3_edge_normalized_top.sv
// 3x3 signed convolution over a raster pixel stream with edge weight normalization
//
// One pixel is taken per transaction; the block then works on it alone. A read state then reads
// the two line memories and shifts the window. Each of the up to four results the pixel
// completes then runs on the single multiply-accumulate unit: nine taps and a closing step.
// It then passes through the restoring divider when the kernel sum is nonzero and the edge
// weight sum is not zero, and waits on the output register until the result is taken. A pixel
// that completes no result goes back to idle after the read state. The line memories need no
// clearing after reset.
module conv3x3_edge_normalized_top
	import c3en_pkg::*;
#(
	parameter int PIXEL_BITS = 8,
	parameter int MAX_WIDTH = 1024
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]     cfg_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [PIXEL_BITS-1:0]   pixel,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [VALUE_BITS-1:0]   value,
	output logic                    run_last,
	output logic                    frame_last
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int ACC_W = PIXEL_BITS + 13;
	localparam int MAG_W = ACC_W - 1;
	localparam int NUM_W = MAG_W + 1;
	localparam int DEN_W = SUM_BITS;
	localparam int REM_W = DEN_W + 1;
	localparam int DC_W = $clog2(NUM_W + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_READ = 3'd1;
	localparam logic [2:0] ST_MAC = 3'd2;
	localparam logic [2:0] ST_DIV = 3'd3;
	localparam logic [2:0] ST_OUT = 3'd4;

	logic [2:0] state_q;
	logic [10:0] width_cfg_q;
	logic [15:0] height_cfg_q;
	logic [8:0] center_q;
	logic [63:0] ring_q;

	logic [CW-1:0] col_q;
	logic [15:0] row_q;
	logic [CW-1:0] c_q;
	logic [15:0] r_q;
	logic [PIXEL_BITS-1:0] pix_q;
	logic [PIXEL_BITS-1:0] win_q [3][3];

	logic [3:0] mask_q;
	logic [1:0] k_q;
	logic [1:0] tr_q, tc_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [SUM_BITS-1:0] full_q, part_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [REM_W-1:0] rem_q;
	logic [DC_W-1:0] dcnt_q;
	logic [VALUE_BITS-1:0] value_q;
	logic frame_last_q;

	logic [31:0] wcfg32;
	logic [CW-1:0] wlast;
	logic [15:0] hlast;
	logic [CW-1:0] c_cur;
	logic [15:0] r_cur;
	logic in_acc, out_acc;
	logic [PIXEL_BITS-1:0] rd_a, rd_b;

	logic [CW-1:0] x_cur;
	logic [15:0] y_cur;
	logic [2:0] wr, wc;
	logic tap_ok;
	logic [PIXEL_BITS-1:0] tap_pix;
	weight_t tap_w;
	logic signed [ACC_W-1:0] prod;
	logic signed [ACC_W-1:0] acc_next;
	logic signed [SUM_BITS-1:0] part_next, full_next;
	logic [MAG_W-1:0] mag;
	logic [DEN_W-1:0] d_abs;
	logic [REM_W-1:0] rem_sh;
	logic [3:0] mask_rest;

	assign wcfg32 = 32'(width_cfg_q);
	assign wlast = (wcfg32 == 32'd0) ? '0 :
		(wcfg32 > 32'(MAX_WIDTH)) ? CW'(MAX_WIDTH - 1) : CW'(wcfg32 - 32'd1);
	assign hlast = (height_cfg_q == 16'd0) ? 16'd0 : height_cfg_q - 16'd1;
	assign c_cur = (col_q > wlast) ? wlast : col_q;
	assign r_cur = (row_q > hlast) ? hlast : row_q;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc = in_valid && !in_stall;
	assign out_valid = (state_q == ST_OUT);
	assign out_acc = out_valid && !out_stall;
	assign value = value_q;
	assign frame_last = frame_last_q;
	assign mask_rest = mask_q & ~(4'd1 << k_q);
	assign run_last = (mask_rest == 4'd0);

	c3en_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_line_a (
		.clk(clk), .we(state_q == ST_READ), .waddr(c_q), .wdata(pix_q),
		.raddr(c_cur), .rdata(rd_a)
	);

	c3en_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_line_b (
		.clk(clk), .we(state_q == ST_READ), .waddr(c_q), .wdata(rd_a),
		.raddr(c_cur), .rdata(rd_b)
	);

	// tap of the current result: k bit 1 picks the lower row, k bit 0 the right column
	always_comb begin
		y_cur = k_q[1] ? r_q : r_q - 16'd1;
		x_cur = k_q[0] ? c_q : c_q - CW'(1);
		wr = (k_q[1] ? 3'd2 : 3'd1) + 3'(tr_q) - 3'd1;
		wc = (k_q[0] ? 3'd2 : 3'd1) + 3'(tc_q) - 3'd1;
		tap_ok = (wr <= 3'd2) && (wc <= 3'd2);
		if (tr_q == 2'd0 && y_cur == 16'd0) tap_ok = 1'b0;
		if (tr_q == 2'd2 && y_cur >= hlast) tap_ok = 1'b0;
		if (tc_q == 2'd0 && x_cur == '0) tap_ok = 1'b0;
		if (tc_q == 2'd2 && x_cur >= wlast) tap_ok = 1'b0;
		tap_pix = tap_ok ? win_q[wr[1:0]][wc[1:0]] : '0;
		tap_w = weight_at(center_q, ring_q, 4'(tr_q) * 4'd3 + 4'(tc_q));
		prod = ACC_W'(tap_w) * ACC_W'($signed({1'b0, tap_pix}));
		acc_next = acc_q + prod;
		full_next = full_q + SUM_BITS'(tap_w);
		part_next = part_q + (tap_ok ? SUM_BITS'(tap_w) : '0);
		mag = acc_q[ACC_W-1] ? MAG_W'(-acc_q) : MAG_W'(acc_q);
		d_abs = part_q[SUM_BITS-1] ? DEN_W'(-part_q) : DEN_W'(part_q);
		rem_sh = {rem_q[REM_W-2:0], num_q[NUM_W-1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_cfg_q <= 11'd1024;
			height_cfg_q <= 16'd1;
			center_q <= 9'd1;
			ring_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH: width_cfg_q <= cfg_data[10:0];
				REG_IMAGE_HEIGHT: height_cfg_q <= cfg_data[15:0];
				REG_KERNEL_CENTER: center_q <= cfg_data[8:0];
				REG_KERNEL_RING: ring_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			col_q <= '0;
			row_q <= '0;
			mask_q <= '0;
			k_q <= '0;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) win_q[i][j] <= '0;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						pix_q <= pixel;
						c_q <= c_cur;
						r_q <= r_cur;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					for (int i = 0; i < 3; i++) begin
						win_q[i][0] <= win_q[i][1];
						win_q[i][1] <= win_q[i][2];
					end
					win_q[0][2] <= rd_b;
					win_q[1][2] <= rd_a;
					win_q[2][2] <= pix_q;
					mask_q <= {(r_q == hlast) && (c_q == wlast), (r_q == hlast) && (c_q != '0),
						(r_q != 16'd0) && (c_q == wlast), (r_q != 16'd0) && (c_q != '0)};
					k_q <= first_set({(r_q == hlast) && (c_q == wlast),
						(r_q == hlast) && (c_q != '0), (r_q != 16'd0) && (c_q == wlast),
						(r_q != 16'd0) && (c_q != '0)});
					if (c_q >= wlast) begin
						col_q <= '0;
						row_q <= (r_q >= hlast) ? 16'd0 : r_q + 16'd1;
					end else begin
						col_q <= c_q + CW'(1);
					end
					tr_q <= '0;
					tc_q <= '0;
					acc_q <= '0;
					full_q <= '0;
					part_q <= '0;
					state_q <= ((r_q != 16'd0) || (r_q == hlast)) &&
						((c_q != '0) || (c_q == wlast)) ? ST_MAC : ST_IDLE;
				end
				ST_MAC: begin
					if (tr_q == 2'd3) begin
						// all nine taps summed
						frame_last_q <= (y_cur == hlast) && (x_cur == wlast);
						if (full_q != '0 && d_abs != '0) begin
							num_q <= NUM_W'({mag, 1'b0}) + NUM_W'(d_abs);
							den_q <= {d_abs[DEN_W-2:0], 1'b0};
							rem_q <= '0;
							dcnt_q <= DC_W'(NUM_W);
							state_q <= ST_DIV;
						end else begin
							value_q <= (MAG_W'(mag) > MAG_W'(VALUE_MAX)) ? VALUE_MAX :
								VALUE_BITS'(mag);
							state_q <= ST_OUT;
						end
					end else begin
						acc_q <= acc_next;
						full_q <= full_next;
						part_q <= part_next;
						if (tc_q == 2'd2) begin
							tc_q <= '0;
							tr_q <= tr_q + 2'd1;
						end else begin
							tc_q <= tc_q + 2'd1;
						end
					end
				end
				ST_DIV: begin
					if (dcnt_q == '0) begin
						value_q <= (num_q > NUM_W'(VALUE_MAX)) ? VALUE_MAX : VALUE_BITS'(num_q);
						state_q <= ST_OUT;
					end else begin
						// one quotient bit per cycle, shifted into the numerator register
						if (rem_sh >= REM_W'(den_q)) begin
							rem_q <= rem_sh - REM_W'(den_q);
							num_q <= {num_q[NUM_W-2:0], 1'b1};
						end else begin
							rem_q <= rem_sh;
							num_q <= {num_q[NUM_W-2:0], 1'b0};
						end
						dcnt_q <= dcnt_q - DC_W'(1);
					end
				end
				ST_OUT: begin
					if (out_acc) begin
						mask_q <= mask_rest;
						k_q <= first_set(mask_rest);
						tr_q <= '0;
						tc_q <= '0;
						acc_q <= '0;
						full_q <= '0;
						part_q <= '0;
						state_q <= (mask_rest == 4'd0) ? ST_IDLE : ST_MAC;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_frame_ends_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_last |-> run_last)
		else $error("frame end not on last result of its pixel");

	a_slot_pending: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> mask_q[k_q])
		else $error("result slot delivered that was not pending");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> den_q != '0)
		else $error("divider running with zero divisor");

	a_last_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && run_last |=> state_q == ST_IDLE)
		else $error("block busy after last result of a pixel");

endmodule
